/* rtl/core/ljpe_pkg.sv */
// Shared constants, register indexes and a helper function for the Lennard-Jones pair evaluator.
package ljpe_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_W         = 32;
   localparam int OUT_W         = 48;

   typedef enum logic [1:0] {
      CSR_SIGMA   = 2'd0,
      CSR_EPSILON = 2'd1,
      CSR_R_MIN   = 2'd2
   } csr_index_type;

   localparam logic [CSR_W-1:0] SIGMA_RST   = 32'd65536;
   localparam logic [CSR_W-1:0] EPSILON_RST = 32'd65536;
   localparam logic [CSR_W-1:0] R_MIN_RST   = 32'd52429;

   localparam logic [63:0] POS_MAX48 = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] NEG_MAG48 = 64'h0000_8000_0000_0000;

   typedef struct packed {
      logic [OUT_W-1:0] value;
      logic             clipped;
   } clip_type;

   // Applies the sign to a magnitude and clips the result to the signed 48-bit range.
   function automatic clip_type clip48(input logic [63:0] mag, input logic neg);
      clip_type   res;
      logic [63:0] m;
      m           = mag;
      res.clipped = 1'b0;
      if (neg) begin
         if (m > NEG_MAG48) begin
            m           = NEG_MAG48;
            res.clipped = 1'b1;
         end
         res.value = OUT_W'(64'd0 - m);
      end else begin
         if (m > POS_MAX48) begin
            m           = POS_MAX48;
            res.clipped = 1'b1;
         end
         res.value = m[OUT_W-1:0];
      end
      return res;
   endfunction

endpackage

/* rtl/core/ljpe_mul.sv */
// Three-stage saturating fixed-point multiplier, 64 by 64 bits, built from 32-bit partial products.
module ljpe_mul #(
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W    = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [63:0]       in_a,
   input  logic [63:0]       in_b,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [63:0]       out_prod,
   output logic              out_sat,
   output logic [SIDE_W-1:0] out_side
);

   logic [63:0]       ll_ff, lh_ff, hl_ff, hh_ff;
   logic [63:0]       ll_in, lh_in, hl_in, hh_in;
   logic [127:0]      sum_ff, sum_in;
   logic [63:0]       prod_ff, prod_in;
   logic              sat_ff, sat_in;
   logic [2:0]        vld_ff;
   logic [SIDE_W-1:0] side1_ff, side2_ff, side3_ff;

   assign ll_in = {32'd0, in_a[31:0]}  * {32'd0, in_b[31:0]};
   assign lh_in = {32'd0, in_a[31:0]}  * {32'd0, in_b[63:32]};
   assign hl_in = {32'd0, in_a[63:32]} * {32'd0, in_b[31:0]};
   assign hh_in = {32'd0, in_a[63:32]} * {32'd0, in_b[63:32]};

   assign sum_in = {64'd0, ll_ff} + {32'd0, lh_ff, 32'd0} + {32'd0, hl_ff, 32'd0}
                 + {hh_ff, 64'd0};

   // Any bit above the kept window means the scaled product does not fit in 64 bits.
   assign sat_in  = |sum_ff[127:64+FRAC_BITS];
   assign prod_in = sat_in ? '1 : sum_ff[63+FRAC_BITS:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff    <= ll_in;
         lh_ff    <= lh_in;
         hl_ff    <= hl_in;
         hh_ff    <= hh_in;
         side1_ff <= in_side;
         sum_ff   <= sum_in;
         side2_ff <= side1_ff;
         prod_ff  <= prod_in;
         sat_ff   <= sat_in;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_prod  = prod_ff;
   assign out_sat   = sat_ff;
   assign out_side  = side3_ff;

endmodule

/* rtl/core/ljpe_div.sv */
// Pipelined restoring divider by a 32-bit divisor, one quotient bit per stage.
module ljpe_div #(
   parameter int DIVIDEND_W = 48,
   parameter int SIDE_W     = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [DIVIDEND_W-1:0] in_dividend,
   input  logic [31:0]           in_divisor,
   input  logic [31:0]           in_rem,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [DIVIDEND_W-1:0] out_quot,
   output logic [SIDE_W-1:0]     out_side
);

   // The work word shifts dividend bits out at the top and quotient bits in at the bottom.
   logic [31:0]           rem_ff  [DIVIDEND_W];
   logic [DIVIDEND_W-1:0] work_ff [DIVIDEND_W];
   logic [31:0]           div_ff  [DIVIDEND_W];
   logic [SIDE_W-1:0]     side_ff [DIVIDEND_W];
   logic                  vld_ff  [DIVIDEND_W];

   for (genvar i = 0; i < DIVIDEND_W; i++) begin : g_step
      logic [31:0]           rem_src, div_src, rem_in;
      logic [DIVIDEND_W-1:0] work_src, work_in;
      logic [SIDE_W-1:0]     side_src;
      logic                  vld_src;
      logic [32:0]           trial;
      logic                  ge;

      if (i == 0) begin : g_first
         assign rem_src  = in_rem;
         assign div_src  = in_divisor;
         assign work_src = in_dividend;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign div_src  = div_ff[i-1];
         assign work_src = work_ff[i-1];
         assign side_src = side_ff[i-1];
         assign vld_src  = vld_ff[i-1];
      end

      assign trial   = {rem_src, work_src[DIVIDEND_W-1]};
      assign ge      = trial >= {1'b0, div_src};
      assign rem_in  = ge ? 32'(trial - {1'b0, div_src}) : trial[31:0];
      assign work_in = {work_src[DIVIDEND_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            work_ff[i] <= work_in;
            div_ff[i]  <= div_src;
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[DIVIDEND_W-1];
   assign out_quot  = work_ff[DIVIDEND_W-1];
   assign out_side  = side_ff[DIVIDEND_W-1];

endmodule

/* rtl/core/lennard_jones_pair_eval.sv */
// Top level of the Lennard-Jones 12-6 pair evaluator: registers, pipeline and output stage.
//
// The block takes one pair distance per item and returns the 12-6 energy and the force
// in signed Q32.16 (FRAC_BITS fraction bits), saturating, with a flag that reports any
// saturation along the way. It is fully pipelined: a new item is accepted every cycle while
// the pipeline does not stall. Its depth is set by the two bit-per-stage dividers, one
// for sigma/r with 32 + FRAC_BITS stages and one for the final division of the force by r
// with 64 stages, plus five three-stage multipliers in series. When the result side stalls,
// the pipeline holds only if its last stage has an item waiting; bubbles still advance, so
// the input keeps accepting items until an item reaches the last stage. Registers sigma,
// epsilon and r_min are written through the csr port and must only change while no item is
// in flight. Writes to an unused index are ignored.
module lennard_jones_pair_eval #(
   parameter int FRAC_BITS = ljpe_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_distance,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [47:0] rsp_pair_energy,
   output logic signed [47:0] rsp_pair_force,
   output logic               rsp_saturated
);

   localparam int S_W = 32 + FRAC_BITS;
   localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

   // Configuration registers.
   logic [31:0] sigma_ff, epsilon_ff, r_min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff   <= ljpe_pkg::SIGMA_RST;
         epsilon_ff <= ljpe_pkg::EPSILON_RST;
         r_min_ff   <= ljpe_pkg::R_MIN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            ljpe_pkg::CSR_SIGMA:   sigma_ff   <= csr_wdata;
            ljpe_pkg::CSR_EPSILON: epsilon_ff <= csr_wdata;
            ljpe_pkg::CSR_R_MIN:   r_min_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline advances together unless a finished item in the last stage has
   // nowhere to go because the output register is still waiting to be taken.
   logic en;
   logic last_vld;
   logic rsp_valid_ff;

   assign en        = !(rsp_valid_ff && !rsp_ready && last_vld);
   assign req_ready = en;

   // Input stage: clamp the distance up to r_min, and never let it reach zero.
   logic        a_vld_ff;
   logic [31:0] a_rc_ff, a_rc_in;

   always_comb begin
      a_rc_in = (req_distance < r_min_ff) ? r_min_ff : req_distance;
      if (a_rc_in == 32'd0) begin
         a_rc_in = 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_valid && req_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_rc_ff <= a_rc_in;
      end
   end

   // s = sigma / r in fixed point.
   logic           q1_vld;
   logic [S_W-1:0] q1_s;
   logic [31:0]    q1_rc;

   ljpe_div #(.DIVIDEND_W(S_W), .SIDE_W(32)) u_div_s (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (a_vld_ff),
      .in_dividend({sigma_ff, {FRAC_BITS{1'b0}}}),
      .in_divisor (a_rc_ff),
      .in_rem     (32'd0),
      .in_side    (a_rc_ff),
      .out_valid  (q1_vld),
      .out_quot   (q1_s),
      .out_side   (q1_rc)
   );

   // s^2, s^4 and s^6, each through its own multiplier.
   logic        m1_vld, m1_sat;
   logic [63:0] m1_s2;
   logic [31:0] m1_rc;

   ljpe_mul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(32)) u_mul_s2 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (q1_vld),
      .in_a     (64'(q1_s)),
      .in_b     (64'(q1_s)),
      .in_side  (q1_rc),
      .out_valid(m1_vld),
      .out_prod (m1_s2),
      .out_sat  (m1_sat),
      .out_side (m1_rc)
   );

   logic        m2_vld, m2_sat;
   logic [63:0] m2_s4;
   logic [96:0] m2_side;

   ljpe_mul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(97)) u_mul_s4 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (m1_vld),
      .in_a     (m1_s2),
      .in_b     (m1_s2),
      .in_side  ({m1_rc, m1_s2, m1_sat}),
      .out_valid(m2_vld),
      .out_prod (m2_s4),
      .out_sat  (m2_sat),
      .out_side (m2_side)
   );

   logic        m3_vld, m3_sat;
   logic [63:0] m3_s6;
   logic [32:0] m3_side;

   ljpe_mul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(33)) u_mul_s6 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (m2_vld),
      .in_a     (m2_s4),
      .in_b     (m2_side[64:1]),
      .in_side  ({m2_side[96:65], m2_side[0] | m2_sat}),
      .out_valid(m3_vld),
      .out_prod (m3_s6),
      .out_sat  (m3_sat),
      .out_side (m3_side)
   );

   // Differences |s^6 - 1| for the energy and |2 s^6 - 1| for the force, with their signs.
   logic        d_vld_ff;
   logic [63:0] d_s6_ff, d_de_ff, d_df_ff;
   logic [31:0] d_rc_ff;
   logic        d_eneg_ff, d_fneg_ff, d_flag_ff;
   logic [63:0] d_de_in, d_df_in, d_t;
   logic        d_eneg_in, d_fneg_in, d_tsat;

   always_comb begin
      d_eneg_in = m3_s6 < ONE_Q;
      d_de_in   = d_eneg_in ? ONE_Q - m3_s6 : m3_s6 - ONE_Q;
      d_tsat    = m3_s6[63];
      d_t       = d_tsat ? '1 : {m3_s6[62:0], 1'b0};
      d_fneg_in = d_t < ONE_Q;
      d_df_in   = d_fneg_in ? ONE_Q - d_t : d_t - ONE_Q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (en) begin
         d_vld_ff <= m3_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_s6_ff   <= m3_s6;
         d_de_ff   <= d_de_in;
         d_df_ff   <= d_df_in;
         d_eneg_ff <= d_eneg_in;
         d_fneg_ff <= d_fneg_in;
         d_rc_ff   <= m3_side[32:1];
         d_flag_ff <= m3_side[0] | m3_sat | d_tsat;
      end
   end

   // s^6 times each difference, then epsilon times that; energy and force side by side.
   logic        m4_vld, m4e_sat, m4f_sat;
   logic [63:0] m4_pe, m4_pf;
   logic [34:0] m4_side;

   ljpe_mul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(35)) u_mul_pe (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (d_vld_ff),
      .in_a     (d_s6_ff),
      .in_b     (d_de_ff),
      .in_side  ({d_rc_ff, d_eneg_ff, d_fneg_ff, d_flag_ff}),
      .out_valid(m4_vld),
      .out_prod (m4_pe),
      .out_sat  (m4e_sat),
      .out_side (m4_side)
   );

   ljpe_mul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_mul_pf (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (d_vld_ff),
      .in_a     (d_s6_ff),
      .in_b     (d_df_ff),
      .in_side  (1'b0),
      .out_valid(),
      .out_prod (m4_pf),
      .out_sat  (m4f_sat),
      .out_side ()
   );

   logic        m5_vld, m5e_sat, m5f_sat;
   logic [63:0] m5_ee, m5_ff;
   logic [34:0] m5_side;

   ljpe_mul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(35)) u_mul_ee (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (m4_vld),
      .in_a     ({32'd0, epsilon_ff}),
      .in_b     (m4_pe),
      .in_side  ({m4_side[34:1], m4_side[0] | m4e_sat | m4f_sat}),
      .out_valid(m5_vld),
      .out_prod (m5_ee),
      .out_sat  (m5e_sat),
      .out_side (m5_side)
   );

   ljpe_mul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_mul_ff (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (m4_vld),
      .in_a     ({32'd0, epsilon_ff}),
      .in_b     (m4_pf),
      .in_side  (1'b0),
      .out_valid(),
      .out_prod (m5_ff),
      .out_sat  (m5f_sat),
      .out_side ()
   );

   // Scale the energy by 4 and the force by 24, saturating at 64 bits.
   logic        s_vld_ff;
   logic [63:0] s_emag_ff, s_fm_ff, s_emag_in;
   logic [31:0] s_rc_ff;
   logic        s_eneg_ff, s_fneg_ff, s_flag_ff;
   logic [68:0] s_f24;
   logic        s_eovf, s_fovf;

   always_comb begin
      s_eovf    = |m5_ee[63:62];
      s_emag_in = s_eovf ? '1 : {m5_ee[61:0], 2'b00};
      s_f24     = ({5'd0, m5_ff} << 4) + ({5'd0, m5_ff} << 3);
      s_fovf    = |s_f24[68:64];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
      end else if (en) begin
         s_vld_ff <= m5_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_emag_ff <= s_emag_in;
         s_fm_ff   <= s_fovf ? '1 : s_f24[63:0];
         s_rc_ff   <= m5_side[34:3];
         s_eneg_ff <= m5_side[2];
         s_fneg_ff <= m5_side[1];
         s_flag_ff <= m5_side[0] | m5e_sat | m5f_sat | s_eovf | s_fovf;
      end
   end

   // The force quotient overflows 64 bits exactly when the top FRAC_BITS bits of the
   // dividend already reach r; otherwise they seed the divider's remainder.
   logic        t_vld_ff;
   logic [63:0] t_dividend_ff;
   logic [31:0] t_rem_ff, t_rc_ff, t_top;
   logic [67:0] t_side_ff;
   logic        t_dovf;

   assign t_top  = {{(32-FRAC_BITS){1'b0}}, s_fm_ff[63:64-FRAC_BITS]};
   assign t_dovf = t_top >= s_rc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff <= 1'b0;
      end else if (en) begin
         t_vld_ff <= s_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_rem_ff      <= t_dovf ? 32'd0 : t_top;
         t_dividend_ff <= {s_fm_ff[63-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
         t_rc_ff       <= s_rc_ff;
         t_side_ff     <= {s_emag_ff, s_eneg_ff, s_fneg_ff, s_flag_ff | t_dovf, t_dovf};
      end
   end

   // Force divided by r.
   logic        q2_vld;
   logic [63:0] q2_quot;
   logic [67:0] q2_side;

   ljpe_div #(.DIVIDEND_W(64), .SIDE_W(68)) u_div_f (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (t_vld_ff),
      .in_dividend(t_dividend_ff),
      .in_divisor (t_rc_ff),
      .in_rem     (t_rem_ff),
      .in_side    (t_side_ff),
      .out_valid  (q2_vld),
      .out_quot   (q2_quot),
      .out_side   (q2_side)
   );

   assign last_vld = q2_vld;

   // Sign, clip to 48 bits and present the item. A zero epsilon forces a clean zero result.
   ljpe_pkg::clip_type e_clip, f_clip;
   logic [63:0]        f_mag;

   assign f_mag  = q2_side[0] ? '1 : q2_quot;
   assign e_clip = ljpe_pkg::clip48(q2_side[67:4], q2_side[3]);
   assign f_clip = ljpe_pkg::clip48(f_mag, q2_side[2]);

   logic [47:0] energy_ff, force_ff;
   logic        sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!(rsp_valid_ff && !rsp_ready)) begin
         rsp_valid_ff <= last_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (!(rsp_valid_ff && !rsp_ready)) begin
         if (epsilon_ff == 32'd0) begin
            energy_ff <= '0;
            force_ff  <= '0;
            sat_ff    <= 1'b0;
         end else begin
            energy_ff <= e_clip.value;
            force_ff  <= f_clip.value;
            sat_ff    <= q2_side[1] | e_clip.clipped | f_clip.clipped;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pair_energy = energy_ff;
   assign rsp_pair_force  = force_ff;
   assign rsp_saturated   = sat_ff;

endmodule

/* rtl/core/ljpe_checker.sv */
// Port-level assertions for the Lennard-Jones pair evaluator, bound to the top level.
module ljpe_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [47:0] rsp_pair_energy,
   input logic signed [47:0] rsp_pair_force,
   input logic               rsp_saturated
);

   // A stalled result item keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pair_energy)
         && $stable(rsp_pair_force) && $stable(rsp_saturated))
      else $error("result item changed while stalled");

   // Input backpressure only ever comes from a result item that is waiting.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a waiting result item");

   // Attraction in the force means s^6 < 1/2, so the energy cannot be positive.
   a_sign_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_pair_force < 0) |-> rsp_pair_energy <= 0)
      else $error("attractive force with positive energy");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item present after reset");

endmodule

bind lennard_jones_pair_eval ljpe_checker u_ljpe_checker (.*);
